[rtl/core/taae_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taae_pkg: shared types and constants
// Payload word types, encoding codes and the register file control bundle.
// ----------------------------------------------------------------------------
package taae_pkg;

  typedef struct packed {
    logic [4:0]  action;
    logic [15:0] hw_first;
    logic [15:0] hw_second;
    logic        in_it;
    logic        last_in_it;
    logic [31:0] pc_value;
  } taae_in_t;

  typedef struct packed {
    logic [3:0]  dest_index;
    logic [31:0] dest_value;
    logic        reg_written;
    logic        pc_written;
    logic [3:0]  flags_nzcv;
    logic        flags_updated;
    logic        unpredictable;
  } taae_out_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  waddr;
    logic [31:0] wdata;
  } taae_wr_t;

  localparam logic [4:0] ACT_ADC_IMM       = 5'd0;
  localparam logic [4:0] ACT_ADC_REG_T1    = 5'd1;
  localparam logic [4:0] ACT_ADC_REG_T2    = 5'd2;
  localparam logic [4:0] ACT_ADD_IMM_T1    = 5'd3;
  localparam logic [4:0] ACT_ADD_IMM_T2    = 5'd4;
  localparam logic [4:0] ACT_ADD_IMM_T3    = 5'd5;
  localparam logic [4:0] ACT_ADD_IMM_T4    = 5'd6;
  localparam logic [4:0] ACT_ADD_REG_T1    = 5'd7;
  localparam logic [4:0] ACT_ADD_REG_T2    = 5'd8;
  localparam logic [4:0] ACT_ADD_REG_T3    = 5'd9;
  localparam logic [4:0] ACT_ADD_SP_IMM_T1 = 5'd10;
  localparam logic [4:0] ACT_ADD_SP_IMM_T2 = 5'd11;
  localparam logic [4:0] ACT_ADD_SP_IMM_T3 = 5'd12;
  localparam logic [4:0] ACT_ADD_SP_IMM_T4 = 5'd13;
  localparam logic [4:0] ACT_ADD_SP_REG_T1 = 5'd14;
  localparam logic [4:0] ACT_ADD_SP_REG_T2 = 5'd15;
  localparam logic [4:0] ACT_ADD_SP_REG_T3 = 5'd16;

  localparam logic [3:0] REG_SP = 4'd13;
  localparam logic [3:0] REG_PC = 4'd15;

  localparam logic [1:0] SH_LSL = 2'd0;
  localparam logic [1:0] SH_LSR = 2'd1;
  localparam logic [1:0] SH_ASR = 2'd2;
  localparam logic [1:0] SH_ROR = 2'd3;

  function automatic logic bad_reg(input logic [3:0] i);
    return (i == REG_SP) || (i == REG_PC);
  endfunction

  function automatic logic [32:0] expand_imm(input logic [11:0] imm12);
    logic [7:0]  m;
    logic [31:0] v;
    logic        bad;
    logic [31:0] base;
    m = imm12[7:0];
    bad = 1'b0;
    v = 32'd0;
    if (imm12[11:10] == 2'b00) begin
      bad = (imm12[9:8] != 2'b00) && (m == 8'd0);
      case (imm12[9:8])
        2'd0: v = {24'd0, m};
        2'd1: v = {8'd0, m, 8'd0, m};
        2'd2: v = {m, 8'd0, m, 8'd0};
        default: v = {m, m, m, m};
      endcase
    end else begin
      base = {24'd0, 1'b1, imm12[6:0]};
      v = (base >> imm12[11:7]) | (base << (6'd32 - {1'b0, imm12[11:7]}));
    end
    return {bad, v};
  endfunction

  function automatic logic [31:0] shift_imm(input logic [31:0] x, input logic [1:0] ty,
                                            input logic [4:0] n, input logic c);
    logic [31:0] r;
    r = x;
    case (ty)
      SH_LSL: r = x << n;
      SH_LSR: r = (n == 5'd0) ? 32'd0 : (x >> n);
      SH_ASR: r = (n == 5'd0) ? {32{x[31]}} : 32'($signed(x) >>> n);
      SH_ROR: r = (n == 5'd0) ? {c, x[31:1]} : ((x >> n) | (x << (6'd32 - {1'b0, n})));
      default: r = x;
    endcase
    return r;
  endfunction

endpackage

[rtl/core/taae_regfile.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taae_regfile: 16 x 32 register file
// Synchronous memory with three registered read ports and one write port; the
// top level's clearing sweep after reset writes zeros to every entry there.
// ----------------------------------------------------------------------------
module taae_regfile
  import taae_pkg::*;
(
  input  logic        clk,
  input  logic [3:0]  ra_addr,
  input  logic [3:0]  rb_addr,
  input  logic [3:0]  rc_addr,
  output logic [31:0] ra_data,
  output logic [31:0] rb_data,
  output logic [31:0] rc_data,
  input  taae_wr_t    wr
);

  logic [31:0] mem [16];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.waddr] <= wr.wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
    rc_data <= mem[rc_addr];
  end

endmodule

[rtl/core/taae_exec.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taae_exec: decode and add
// Decodes the encoding, forms operands and the sum, and builds the result.
// ----------------------------------------------------------------------------
module taae_exec
  import taae_pkg::*;
(
  input  taae_in_t    word,
  input  logic [31:0] ra_data,
  input  logic [31:0] rb_data,
  input  logic [31:0] sp_data,
  input  logic [3:0]  flags,
  output taae_out_t   res,
  output taae_wr_t    wr,
  output logic        flag_we
);

  logic [15:0] h;
  logic [15:0] l;
  logic [3:0]  d32;
  logic [3:0]  m32;
  logic [3:0]  n32;
  logic [1:0]  stype;
  logic [4:0]  simm5;
  logic [11:0] imm12;
  logic [32:0] eimm;
  logic [31:0] shv;
  logic [31:0] x;
  logic [31:0] y;
  logic        cin;
  logic [3:0]  d;
  logic        sf;
  logic        unp;
  logic        topc;
  logic [3:0]  dh;
  logic [32:0] wide;
  logic [31:0] sum;
  logic        v;

  always_comb begin
    h = word.hw_first;
    l = word.hw_second;
    d32 = l[11:8];
    n32 = h[3:0];
    m32 = l[3:0];
    stype = l[5:4];
    simm5 = {l[14:12], l[7:6]};
    imm12 = {h[10], l[14:12], l[7:0]};
    eimm = expand_imm(imm12);
    shv = shift_imm(rb_data, stype, simm5, flags[1]);
    dh = {h[7], h[2:0]};
    x = ra_data;
    y = 32'd0;
    cin = 1'b0;
    d = 4'd0;
    sf = 1'b0;
    unp = 1'b0;
    topc = 1'b0;
    case (word.action)
      ACT_ADC_IMM: begin
        unp = bad_reg(d32) || bad_reg(n32) || eimm[32];
        d = d32; y = eimm[31:0]; cin = flags[1]; sf = h[4];
      end
      ACT_ADC_REG_T1: begin
        d = {1'b0, h[2:0]}; y = rb_data; cin = flags[1]; sf = !word.in_it;
      end
      ACT_ADC_REG_T2: begin
        unp = bad_reg(d32) || bad_reg(n32) || bad_reg(m32);
        d = d32; y = shv; cin = flags[1]; sf = h[4];
      end
      ACT_ADD_IMM_T1: begin
        d = {1'b0, h[2:0]}; y = {29'd0, h[8:6]}; sf = !word.in_it;
      end
      ACT_ADD_IMM_T2: begin
        d = {1'b0, h[10:8]}; y = {24'd0, h[7:0]}; sf = !word.in_it;
      end
      ACT_ADD_IMM_T3: begin
        unp = bad_reg(d32) || (n32 == REG_PC) || eimm[32];
        d = d32; y = eimm[31:0]; sf = h[4];
      end
      ACT_ADD_IMM_T4: begin
        unp = bad_reg(d32); d = d32; y = {20'd0, imm12};
      end
      ACT_ADD_REG_T1: begin
        d = {1'b0, h[2:0]}; y = rb_data; sf = !word.in_it;
      end
      ACT_ADD_REG_T2: begin
        d = dh;
        unp = (dh == REG_PC && word.in_it && !word.last_in_it) ||
              (dh == REG_PC && h[6:3] == REG_PC);
        y = rb_data; topc = (dh == REG_PC);
      end
      ACT_ADD_REG_T3: begin
        d = d32; y = shv; topc = (d32 == REG_PC); sf = h[4] && (d32 != REG_PC);
      end
      ACT_ADD_SP_IMM_T1: begin
        d = {1'b0, h[10:8]}; x = sp_data; y = {22'd0, h[7:0], 2'b00};
      end
      ACT_ADD_SP_IMM_T2: begin
        d = REG_SP; x = sp_data; y = {23'd0, h[6:0], 2'b00};
      end
      ACT_ADD_SP_IMM_T3: begin
        unp = (d32 == REG_PC) || eimm[32];
        d = d32; x = sp_data; y = eimm[31:0]; sf = h[4];
      end
      ACT_ADD_SP_IMM_T4: begin
        unp = (d32 == REG_PC); d = d32; x = sp_data; y = {20'd0, imm12};
      end
      ACT_ADD_SP_REG_T1: begin
        d = dh; unp = (dh == REG_PC) && word.in_it && !word.last_in_it;
        x = sp_data; y = ra_data; topc = (dh == REG_PC);
      end
      ACT_ADD_SP_REG_T2: begin
        d = REG_SP; x = sp_data; y = rb_data;
      end
      ACT_ADD_SP_REG_T3: begin
        unp = ((d32 == REG_SP) && ((stype != SH_LSL) || (simm5 > 5'd3))) ||
              (d32 == REG_PC) || bad_reg(m32);
        d = d32; x = sp_data; y = shv; sf = h[4];
      end
      default: unp = 1'b1;
    endcase
    wide = {1'b0, x} + {1'b0, y} + {32'd0, cin};
    sum = wide[31:0];
    v = (~(x[31] ^ y[31])) & (x[31] ^ sum[31]);
    flag_we = !unp && sf;
    wr.we = !unp && !topc;
    wr.waddr = d;
    wr.wdata = sum;
    res.dest_index = unp ? 4'd0 : d;
    res.dest_value = unp ? 32'd0 : sum;
    res.reg_written = !unp && !topc;
    res.pc_written = !unp && topc;
    res.flags_nzcv = flag_we ? {sum[31], sum == 32'd0, wide[32], v} : flags;
    res.flags_updated = flag_we;
    res.unpredictable = unp;
  end

endmodule

[rtl/core/thumb_add_adc_execute_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thumb_add_adc_execute_top: Thumb ADC/ADD execute stage
// channel | dir | handshake            | word
// in      | in  | in_valid/in_ready    | taae_in_t
// out     | out | out_valid/out_ready  | taae_out_t
// One word per cycle: stage 1 issues register file reads, stage 2 adds and
// writes back; a write in stage 2 is forwarded to the reads for stage 1.
// Reset sweeps the 16-entry register file to zero, with in_ready low.
// A full output register with out_ready low stalls both stages.
// ----------------------------------------------------------------------------
module thumb_add_adc_execute_top
  import taae_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  taae_in_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output taae_out_t out_data
);

  logic        clr_r, clr_nxt;
  logic [3:0]  clr_cnt_r;
  logic        s2_valid_r;
  taae_in_t    s2_word_r;
  logic [3:0]  ra_addr_r, rb_addr_r;
  logic        fwd_a_r, fwd_b_r, fwd_s_r;
  logic [31:0] fwd_data_r;
  logic [3:0]  flags_r;
  logic        out_valid_r;
  taae_out_t   out_r;
  logic [3:0]  ra_addr, rb_addr;
  logic [31:0] ra_mem, rb_mem, sp_mem;
  logic [31:0] ra_data, rb_data, sp_data;
  taae_out_t   res;
  taae_wr_t    ex_wr, wr;
  logic        flag_we, adv, s2_fire;
  logic [15:0] h, l;

  assign adv = !out_valid_r || out_ready;
  assign s2_fire = s2_valid_r && adv;
  assign in_ready = adv && !clr_r;
  assign out_valid = out_valid_r;
  assign out_data = out_r;

  always_comb begin
    h = in_data.hw_first;
    l = in_data.hw_second;
    ra_addr = h[3:0];
    rb_addr = l[3:0];
    case (in_data.action)
      ACT_ADC_REG_T1, ACT_ADD_IMM_T2, ACT_ADD_SP_REG_T1: begin
        ra_addr = (in_data.action == ACT_ADD_IMM_T2) ? {1'b0, h[10:8]} :
                  (in_data.action == ACT_ADC_REG_T1) ? {1'b0, h[2:0]} :
                  {h[7], h[2:0]};
        rb_addr = {1'b0, h[5:3]};
      end
      ACT_ADD_IMM_T1: ra_addr = {1'b0, h[5:3]};
      ACT_ADD_REG_T1: begin ra_addr = {1'b0, h[5:3]}; rb_addr = {1'b0, h[8:6]}; end
      ACT_ADD_REG_T2: begin ra_addr = {h[7], h[2:0]}; rb_addr = h[6:3]; end
      ACT_ADD_SP_REG_T2: rb_addr = h[6:3];
      default: ;
    endcase
  end

  always_comb begin
    wr = ex_wr;
    wr.we = ex_wr.we && s2_fire;
    if (clr_r) begin
      wr.we = 1'b1; wr.waddr = clr_cnt_r; wr.wdata = 32'd0;
    end
    clr_nxt = clr_r && (clr_cnt_r != 4'd15);
  end

  taae_regfile u_rf (
    .clk(clk), .ra_addr(adv ? ra_addr : ra_addr_r), .rb_addr(adv ? rb_addr : rb_addr_r),
    .rc_addr(REG_SP), .ra_data(ra_mem), .rb_data(rb_mem), .rc_data(sp_mem), .wr(wr));

  always_comb begin
    ra_data = fwd_a_r ? fwd_data_r : ra_mem;
    rb_data = fwd_b_r ? fwd_data_r : rb_mem;
    sp_data = fwd_s_r ? fwd_data_r : sp_mem;
    if (ra_addr_r == REG_PC) ra_data = s2_word_r.pc_value;
    if (rb_addr_r == REG_PC) rb_data = s2_word_r.pc_value;
  end

  taae_exec u_ex (
    .word(s2_word_r), .ra_data(ra_data), .rb_data(rb_data), .sp_data(sp_data),
    .flags(flags_r), .res(res), .wr(ex_wr), .flag_we(flag_we));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= 1'b1;
      clr_cnt_r <= 4'd0;
      s2_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      flags_r <= 4'd0;
    end else begin
      clr_r <= clr_nxt;
      clr_cnt_r <= clr_cnt_r + 4'd1;
      if (s2_fire && flag_we) flags_r <= res.flags_nzcv;
      if (adv) begin
        s2_valid_r <= in_valid && in_ready;
        out_valid_r <= s2_valid_r;
      end
    end
  end

  // hold payload while stalled; refresh stage-2 read data via forwarding
  always_ff @(posedge clk) begin
    if (adv) begin
      s2_word_r <= in_data;
      ra_addr_r <= ra_addr;
      rb_addr_r <= rb_addr;
      fwd_a_r <= wr.we && (wr.waddr == ra_addr);
      fwd_b_r <= wr.we && (wr.waddr == rb_addr);
      fwd_s_r <= wr.we && (wr.waddr == REG_SP);
      fwd_data_r <= wr.wdata;
      if (s2_valid_r) out_r <= res;
    end
  end

  a_unp_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_fire && res.unpredictable) |-> !wr.we && !flag_we)
    else $error("unpredictable word changed state");
  a_pc_no_reg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.pc_written) |-> !out_data.reg_written)
    else $error("pc and register both written");
  a_clr_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    clr_r |-> !in_ready)
    else $error("input taken during clear sweep");
  a_flags_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(s2_fire && flag_we) |=> $stable(flags_r))
    else $error("flags changed without update");

endmodule
